// ===== rtl/core/rmkl_pkg.sv =====
// package for the record and match key lock
// key kinds, lock modes, field widths and default sizes; no dependencies
package rmkl_pkg;

   localparam int CODE_DEPTH_DEF = 128;
   localparam int KIND_W         = 2;
   localparam int CP_W           = 21;
   localparam int MODE_W         = 2;
   localparam int POS_OUT_W      = 7;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_BUTTON = 2'd0,
      KIND_ESCAPE = 2'd1,
      KIND_ENTER  = 2'd2,
      KIND_CHAR   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      MODE_WAIT    = 3'b001,
      MODE_RECORD  = 3'b010,
      MODE_COMPARE = 3'b100
   } mode_type;

   localparam logic [MODE_W-1:0] LOCK_MODE_WAIT    = 2'd0;
   localparam logic [MODE_W-1:0] LOCK_MODE_RECORD  = 2'd1;
   localparam logic [MODE_W-1:0] LOCK_MODE_COMPARE = 2'd2;

   function automatic logic [MODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_W-1:0] c;
      case (m)
         MODE_RECORD:  c = LOCK_MODE_RECORD;
         MODE_COMPARE: c = LOCK_MODE_COMPARE;
         default:      c = LOCK_MODE_WAIT;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/rmkl_ram.sv =====
// code store: one write port, one registered read port
// a write to the entry being read is forwarded to the read data; uses rmkl_pkg
module rmkl_ram
   import rmkl_pkg::*;
#(
   parameter int DEPTH = CODE_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [CP_W-1:0] wr_data,
   input  logic [AW-1:0]   rd_addr,
   output logic [CP_W-1:0] rd_data
);

   logic [CP_W-1:0] mem [DEPTH];
   logic [CP_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/record_and_match_key_lock.sv =====
// record and match key lock: records a key code, then unlocks when it is typed again
// uses rmkl_pkg and the code store rmkl_ram
//
// channel  direction  tdata                                   tuser
// req      in         codepoint[20:0]                         key_kind[1:0]
// rsp      out        unlocked[0] lock_mode[2:1] pos[9:3]     -
//
// one item per cycle sustained while results are taken; one result per item, valid in the cycle after it is taken
// the store is read ahead at the next position every cycle, so the entry for the
// next item is ready when it arrives; a write to that entry is forwarded
// reset (synchronous) clears mode, position, length and unlock; the store is not cleared
// req_tready stays low while reset is high
// a stalled result holds req_tready low until it is taken
module record_and_match_key_lock
   import rmkl_pkg::*;
#(
   parameter int CODE_DEPTH = CODE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // codepoint[20:0], zero fill
   input  logic [KIND_W-1:0]     req_tuser,  // key_kind[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // unlocked, lock_mode[1:0], match_position[6:0]
);

   localparam int PW = $clog2(CODE_DEPTH);
   localparam logic [PW-1:0] POS_LAST = PW'(CODE_DEPTH - 1);

   mode_type              mode_ff, mode_in, mode_eff;
   logic [PW-1:0]         pos_ff, pos_in, pos_inc;
   logic [POS_OUT_W-1:0]  len_ff, len_in;
   logic                  unlock_ff, unlock_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   kind_type              kind;
   logic [CP_W-1:0]       cp;
   logic [CP_W-1:0]       stored_cp;
   logic                  wr_en;
   logic [PW+POS_OUT_W-1:0] pos_ext, inc_ext, len_ext;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign cp         = req_tdata[CP_W-1:0];

   assign pos_inc = (pos_ff == POS_LAST) ? '0 : pos_ff + PW'(1);
   assign pos_ext = {{POS_OUT_W{1'b0}}, pos_ff};
   assign inc_ext = {{POS_OUT_W{1'b0}}, pos_inc};
   assign len_ext = {{PW{1'b0}}, len_ff};

   always_comb begin
      mode_eff  = (mode_ff == MODE_RECORD || mode_ff == MODE_COMPARE) ? mode_ff : MODE_RECORD;
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      unlock_in = unlock_ff;
      wr_en     = 1'b0;
      if (accept) begin
         mode_in = mode_eff;
         case (kind)
            KIND_ESCAPE: begin
               pos_in = '0;
            end
            KIND_ENTER: begin
               if ((pos_ff != '0) && (mode_eff == MODE_RECORD)) begin
                  len_in  = pos_ext[POS_OUT_W-1:0];
                  mode_in = MODE_COMPARE;
               end
               pos_in = '0;
            end
            KIND_CHAR: begin
               if (mode_eff == MODE_RECORD) begin
                  wr_en  = 1'b1;
                  pos_in = pos_inc;
               end else if (stored_cp != cp) begin
                  pos_in = '0;
               end else begin
                  pos_in = pos_inc;
                  if (inc_ext == len_ext) begin
                     unlock_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   logic [PW+POS_OUT_W-1:0] pos_in_ext;
   assign pos_in_ext = {{POS_OUT_W{1'b0}}, pos_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W - 1 - MODE_W - POS_OUT_W){1'b0}},
                         pos_in_ext[POS_OUT_W-1:0], mode_code(mode_in), unlock_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WAIT;
         pos_ff       <= '0;
         len_ff       <= '0;
         unlock_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         unlock_ff    <= unlock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   rmkl_ram #(
      .DEPTH (CODE_DEPTH),
      .AW    (PW)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff),
      .wr_data (cp),
      .rd_addr (pos_in),
      .rd_data (stored_cp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_unlock_sticky: assert property (@(posedge clock) disable iff (reset)
      unlock_ff |=> unlock_ff)
      else $error("unlock flag cleared");

   a_compare_sticky: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_COMPARE) |=> (mode_ff == MODE_COMPARE))
      else $error("left compare mode");

   a_unlock_mode: assert property (@(posedge clock) disable iff (reset)
      unlock_ff |-> (mode_ff == MODE_COMPARE))
      else $error("unlocked outside compare mode");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted item gave no result");

endmodule
